// ----- src/krlt_pkg.sv -----
// Shared constants for the keyed rate limit table.
// No dependencies; imported by the top level.
package krlt_pkg;

   localparam int KEY_W       = 64;
   localparam int TIME_W      = 32;
   localparam int IVAL_W      = 31;
   localparam int VERDICT_W   = 2;
   localparam int COUNT_OUT_W = 7;

   localparam logic [VERDICT_W-1:0] VERDICT_ALLOW  = 2'd0;
   localparam logic [VERDICT_W-1:0] VERDICT_FORBID = 2'd1;
   localparam logic [VERDICT_W-1:0] VERDICT_FULL   = 2'd2;

endpackage

// ----- src/krlt_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module krlt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- src/keyed_rate_limit_table.sv -----
// Keyed rate limiter: per-key timestamps in RAM, LRU list links, sequencer.
// Depends on krlt_pkg and krlt_ram.
//
//  channel | direction | handshake            | payload
//  req     | in        | req_valid/req_stall  | req_flow_key[63:0], req_now_ms[31:0]
//  rsp     | out       | rsp_valid/rsp_stall  | rsp_verdict[1:0], rsp_entry_count[6:0]
//  csr     | in/out    | APB psel/penable     | reg 0 interval_ms at byte address 0
//
// Each transaction runs in order: accept, expiry (stale entries dropped from the oldest
// end; each expiry step is one read/modify/write of the link RAMs), disabled check,
// key search (one entry per cycle), resolve and list update, response. A disabled
// block (interval 0) skips the search.
// Reset is synchronous; it clears the valid bits, the entry count and the
// sequencer. No clearing pass is needed. A stalled result waits in the output
// register while the next request is already taken in.
module keyed_rate_limit_table
   import krlt_pkg::*;
#(
   parameter int TABLE_ENTRIES = 64
) (
   input  logic                   clock,
   input  logic                   reset,
   // request channel
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [KEY_W-1:0]       req_flow_key,
   input  logic [TIME_W-1:0]      req_now_ms,
   // result channel
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [VERDICT_W-1:0]   rsp_verdict,
   output logic [COUNT_OUT_W-1:0] rsp_entry_count,
   // configuration port
   input  logic                   csr_psel,
   input  logic                   csr_penable,
   input  logic                   csr_pwrite,
   input  logic [2:0]             csr_paddr,
   input  logic [31:0]            csr_pwdata,
   output logic [31:0]            csr_prdata,
   output logic                   csr_pready
);

   localparam int IW = $clog2(TABLE_ENTRIES);
   localparam int AW = IW + 1;
   localparam int CW = $clog2(TABLE_ENTRIES + 1);
   localparam logic [AW-1:0] ADDR_END = AW'(TABLE_ENTRIES);
   localparam logic [CW-1:0] COUNT_MAX = CW'(TABLE_ENTRIES);

   // sequencer codes
   localparam logic [3:0] S_IDLE    = 4'd0;
   localparam logic [3:0] S_EXP_RD  = 4'd1;  // read oldest entry
   localparam logic [3:0] S_EXP_CHK = 4'd2;  // drop it if stale
   localparam logic [3:0] S_POST    = 4'd3;  // disabled check
   localparam logic [3:0] S_SCAN    = 4'd4;  // key search
   localparam logic [3:0] S_RES     = 4'd5;  // hit / insert / full
   localparam logic [3:0] S_HIT     = 4'd6;  // age check of hit entry
   localparam logic [3:0] S_LINK1   = 4'd7;  // unlink hit entry
   localparam logic [3:0] S_LINK2   = 4'd8;  // older link of new newest
   localparam logic [3:0] S_LINK3   = 4'd9;  // newer link self, newest update
   localparam logic [3:0] S_DONE    = 4'd10;

   // ---------------- configuration ----------------
   logic [IVAL_W-1:0] interval_ff;
   logic              csr_wr;

   assign csr_wr     = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == 1'b0) ? {1'b0, interval_ff} : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         interval_ff <= '0;
      end else if (csr_wr && csr_paddr[2] == 1'b0) begin
         interval_ff <= csr_pwdata[IVAL_W-1:0];
      end
   end

   // ---------------- state ----------------
   logic [3:0]               state_ff, state_in;
   logic [KEY_W-1:0]         key_ff, key_in;
   logic [TIME_W-1:0]        now_ff, now_in;
   logic [IW-1:0]            newest_ff, newest_in;
   logic [IW-1:0]            oldest_ff, oldest_in;
   logic [CW-1:0]            count_ff, count_in;
   logic [TABLE_ENTRIES-1:0] valid_ff, valid_in;
   logic [AW-1:0]            addr_ff, addr_in;
   logic                     cmp_vld_ff, cmp_vld_in;
   logic [IW-1:0]            cmp_idx_ff, cmp_idx_in;
   logic [IW-1:0]            found_ff, found_in;
   logic                     found_hit_ff, found_hit_in;
   logic [IW-1:0]            free_ff, free_in;
   logic                     free_hit_ff, free_hit_in;
   logic [IW-1:0]            tgt_ff, tgt_in;
   logic                     link_prev_ff, link_prev_in;
   logic [IW-1:0]            lnk_n_ff, lnk_n_in;
   logic [IW-1:0]            lnk_o_ff, lnk_o_in;
   logic [VERDICT_W-1:0]     verdict_ff, verdict_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [VERDICT_W-1:0]     rsp_verdict_ff, rsp_verdict_in;
   logic [COUNT_OUT_W-1:0]   rsp_count_ff, rsp_count_in;

   // RAM ports
   logic [IW-1:0]     rd_addr;
   logic [KEY_W-1:0]  key_q;
   logic [TIME_W-1:0] time_q;
   logic [IW-1:0]     newer_q, older_q;
   logic              kt_we;
   logic [IW-1:0]     kt_waddr;
   logic              newer_we, older_we;
   logic [IW-1:0]     newer_waddr, older_waddr;
   logic [IW-1:0]     newer_wdata, older_wdata;

   krlt_ram #(.WIDTH(KEY_W), .DEPTH(TABLE_ENTRIES)) u_key_ram (
      .clock(clock), .wr_en(kt_we), .wr_addr(kt_waddr), .wr_data(key_ff),
      .rd_addr(rd_addr), .rd_data(key_q)
   );
   krlt_ram #(.WIDTH(TIME_W), .DEPTH(TABLE_ENTRIES)) u_time_ram (
      .clock(clock), .wr_en(kt_we), .wr_addr(kt_waddr), .wr_data(now_ff),
      .rd_addr(rd_addr), .rd_data(time_q)
   );
   krlt_ram #(.WIDTH(IW), .DEPTH(TABLE_ENTRIES)) u_newer_ram (
      .clock(clock), .wr_en(newer_we), .wr_addr(newer_waddr), .wr_data(newer_wdata),
      .rd_addr(rd_addr), .rd_data(newer_q)
   );
   krlt_ram #(.WIDTH(IW), .DEPTH(TABLE_ENTRIES)) u_older_ram (
      .clock(clock), .wr_en(older_we), .wr_addr(older_waddr), .wr_data(older_wdata),
      .rd_addr(rd_addr), .rd_data(older_q)
   );

   // signed age of the entry just read
   logic signed [TIME_W-1:0] age;
   logic signed [TIME_W-1:0] ival_s;
   logic                     out_free;

   assign age      = $signed(now_ff - time_q);
   assign ival_s   = $signed({1'b0, interval_ff});
   assign out_free = !rsp_valid_ff || !rsp_stall;

   assign req_stall       = (state_ff != S_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_verdict     = rsp_verdict_ff;
   assign rsp_entry_count = rsp_count_ff;

   always_comb begin
      state_in       = state_ff;
      key_in         = key_ff;
      now_in         = now_ff;
      newest_in      = newest_ff;
      oldest_in      = oldest_ff;
      count_in       = count_ff;
      valid_in       = valid_ff;
      addr_in        = addr_ff;
      cmp_vld_in     = 1'b0;
      cmp_idx_in     = cmp_idx_ff;
      found_in       = found_ff;
      found_hit_in   = found_hit_ff;
      free_in        = free_ff;
      free_hit_in    = free_hit_ff;
      tgt_in         = tgt_ff;
      link_prev_in   = link_prev_ff;
      lnk_n_in       = lnk_n_ff;
      lnk_o_in       = lnk_o_ff;
      verdict_in     = verdict_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_verdict_in = rsp_verdict_ff;
      rsp_count_in   = rsp_count_ff;
      rd_addr        = oldest_ff;
      kt_we          = 1'b0;
      kt_waddr       = tgt_ff;
      newer_we       = 1'b0;
      newer_waddr    = tgt_ff;
      newer_wdata    = tgt_ff;
      older_we       = 1'b0;
      older_waddr    = tgt_ff;
      older_wdata    = tgt_ff;

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               key_in   = req_flow_key;
               now_in   = req_now_ms;
               state_in = S_EXP_RD;
            end
         end
         S_EXP_RD: begin
            rd_addr = oldest_ff;
            if (count_ff == '0) begin
               state_in = S_POST;
            end else begin
               state_in = S_EXP_CHK;
            end
         end
         S_EXP_CHK: begin
            if (age >= ival_s) begin
               valid_in[oldest_ff] = 1'b0;
               count_in            = count_ff - CW'(1);
               if (oldest_ff == newest_ff) begin
                  newest_in = older_q;
               end else begin
                  older_we    = 1'b1;
                  older_waddr = newer_q;
                  older_wdata = older_q;
               end
               oldest_in = newer_q;
               state_in  = S_EXP_RD;
            end else begin
               state_in = S_POST;
            end
         end
         S_POST: begin
            if (interval_ff == '0) begin
               valid_in   = '0;
               count_in   = '0;
               verdict_in = VERDICT_ALLOW;
               state_in   = S_DONE;
            end else begin
               addr_in      = '0;
               found_hit_in = 1'b0;
               free_hit_in  = 1'b0;
               state_in     = S_SCAN;
            end
         end
         S_SCAN: begin
            // issue stage
            if (addr_ff != ADDR_END) begin
               rd_addr    = addr_ff[IW-1:0];
               cmp_vld_in = 1'b1;
               cmp_idx_in = addr_ff[IW-1:0];
               addr_in    = addr_ff + AW'(1);
            end else if (!cmp_vld_ff) begin
               state_in = S_RES;
            end
            // compare stage
            if (cmp_vld_ff) begin
               if (valid_ff[cmp_idx_ff]) begin
                  if (!found_hit_ff && key_q == key_ff) begin
                     found_in     = cmp_idx_ff;
                     found_hit_in = 1'b1;
                  end
               end else if (!free_hit_ff) begin
                  free_in     = cmp_idx_ff;
                  free_hit_in = 1'b1;
               end
            end
         end
         S_RES: begin
            rd_addr = found_ff;
            if (found_hit_ff) begin
               state_in = S_HIT;
            end else if (free_hit_ff) begin
               valid_in[free_ff] = 1'b1;
               tgt_in            = free_ff;
               link_prev_in      = (count_ff != '0);
               count_in          = count_ff + CW'(1);
               state_in          = S_LINK2;
            end else begin
               verdict_in = VERDICT_FULL;
               state_in   = S_DONE;
            end
         end
         S_HIT: begin
            if (age > ival_s) begin
               kt_we        = 1'b1;
               kt_waddr     = found_ff;
               tgt_in       = found_ff;
               link_prev_in = 1'b1;
               lnk_n_in     = newer_q;
               lnk_o_in     = older_q;
               verdict_in   = VERDICT_ALLOW;
               if (found_ff == newest_ff) begin
                  state_in = S_DONE;
               end else begin
                  state_in = S_LINK1;
               end
            end else begin
               verdict_in = VERDICT_FORBID;
               state_in   = S_DONE;
            end
         end
         S_LINK1: begin
            older_we    = 1'b1;
            older_waddr = lnk_n_ff;
            older_wdata = lnk_o_ff;
            if (tgt_ff == oldest_ff) begin
               oldest_in = lnk_n_ff;
            end else begin
               newer_we    = 1'b1;
               newer_waddr = lnk_o_ff;
               newer_wdata = lnk_n_ff;
            end
            state_in = S_LINK2;
         end
         S_LINK2: begin
            kt_we       = 1'b1;
            kt_waddr    = tgt_ff;
            older_we    = 1'b1;
            older_waddr = tgt_ff;
            if (link_prev_ff) begin
               older_wdata = newest_ff;
               newer_we    = 1'b1;
               newer_waddr = newest_ff;
               newer_wdata = tgt_ff;
            end else begin
               older_wdata = tgt_ff;
               oldest_in   = tgt_ff;
            end
            state_in = S_LINK3;
         end
         S_LINK3: begin
            newer_we    = 1'b1;
            newer_waddr = tgt_ff;
            newer_wdata = tgt_ff;
            newest_in   = tgt_ff;
            verdict_in  = VERDICT_ALLOW;
            state_in    = S_DONE;
         end
         S_DONE: begin
            if (out_free) begin
               rsp_valid_in   = 1'b1;
               rsp_verdict_in = verdict_ff;
               rsp_count_in   = COUNT_OUT_W'(count_ff);
               state_in       = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         valid_ff     <= '0;
         cmp_vld_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         valid_ff     <= valid_in;
         cmp_vld_ff   <= cmp_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff         <= key_in;
      now_ff         <= now_in;
      newest_ff      <= newest_in;
      oldest_ff      <= oldest_in;
      addr_ff        <= addr_in;
      cmp_idx_ff     <= cmp_idx_in;
      found_ff       <= found_in;
      found_hit_ff   <= found_hit_in;
      free_ff        <= free_in;
      free_hit_ff    <= free_hit_in;
      tgt_ff         <= tgt_in;
      link_prev_ff   <= link_prev_in;
      lnk_n_ff       <= lnk_n_in;
      lnk_o_ff       <= lnk_o_in;
      verdict_ff     <= verdict_in;
      rsp_verdict_ff <= rsp_verdict_in;
      rsp_count_ff   <= rsp_count_in;
   end

   // ---------------- checks ----------------
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_MAX)
      else $error("entry count above table size");

   a_count_matches_valid: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_IDLE |-> $countones(valid_ff) == int'(count_ff))
      else $error("entry count differs from valid bits");

   a_full_only_when_full: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DONE && verdict_ff == VERDICT_FULL) |-> count_ff == COUNT_MAX)
      else $error("table full verdict with free slots");

   a_disabled_empty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DONE && interval_ff == '0) |-> count_ff == '0)
      else $error("disabled block left entries");

endmodule

// ----- verif/tb_keyed_rate_limit_table.sv -----
// Self-checking testbench for the keyed rate limit table.
// Depends on krlt_pkg and the keyed_rate_limit_table RTL.
module tb_keyed_rate_limit_table;
   import krlt_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int ENTRIES   = 64;
   localparam int DRAIN_CYC = 400;

   typedef struct packed {
      logic [KEY_W-1:0]  flow_key;
      logic [TIME_W-1:0] now_ms;
   } request_type;

   typedef struct packed {
      logic [VERDICT_W-1:0]   verdict;
      logic [COUNT_OUT_W-1:0] entry_count;
   } verdict_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0, req_stall;
   logic [KEY_W-1:0]  req_flow_key = '0;
   logic [TIME_W-1:0] req_now_ms = '0;
   logic rsp_valid, rsp_stall = 1'b0;
   logic [VERDICT_W-1:0]   rsp_verdict;
   logic [COUNT_OUT_W-1:0] rsp_entry_count;
   logic csr_psel = 1'b0, csr_penable = 1'b0, csr_pwrite = 1'b0;
   logic [2:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic csr_pready;

   keyed_rate_limit_table DUT (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ---------------------------------------------------------------------------
   // Predictor state: shadow limiter table with its own recency list.
   // ---------------------------------------------------------------------------
   logic [IVAL_W-1:0] lim_interval;
   logic              tbl_valid [ENTRIES];
   logic [KEY_W-1:0]  tbl_key   [ENTRIES];
   logic [TIME_W-1:0] tbl_time  [ENTRIES];
   int                lnk_newer [ENTRIES];
   int                lnk_older [ENTRIES];
   int                head_new, tail_old, tracked;

   request_type pending_reqs[$];
   verdict_type expected_verdicts[$];
   int  failures = 0;
   bit  quiet = 1'b0;        // no idling in the last part of the run
   bit  long_hold = 1'b0;    // receiver hold-off requested
   int  hold_cycles = 0;
   int  key_pool_size = 8;   // small key pool gives hits, larger fills the table

   function automatic longint age_of(logic [TIME_W-1:0] now, logic [TIME_W-1:0] last);
      logic signed [TIME_W-1:0] d;
      d = now - last;
      return longint'(d);
   endfunction

   function automatic void list_remove(int s);
      int n, o;
      n = lnk_newer[s];
      o = lnk_older[s];
      if (s == head_new) head_new = o;
      else lnk_older[n] = o;
      if (s == tail_old) tail_old = n;
      else lnk_newer[o] = n;
   endfunction

   function automatic void list_push(int s, bit empty);
      if (empty) begin
         tail_old = s;
         lnk_older[s] = s;
      end else begin
         lnk_older[s] = head_new;
         lnk_newer[head_new] = s;
      end
      lnk_newer[s] = s;
      head_new = s;
   endfunction

   function automatic verdict_type rate_limit_decide(request_type r);
      verdict_type v;
      longint ival;
      int hit, free_slot, s;
      ival = longint'(lim_interval);
      v.verdict = VERDICT_ALLOW;
      // drop stale entries from the oldest end
      for (int i = 0; i < ENTRIES && tracked > 0; i++) begin
         s = tail_old;
         if (age_of(r.now_ms, tbl_time[s]) < ival) break;
         list_remove(s);
         tbl_valid[s] = 1'b0;
         tracked--;
      end
      if (lim_interval == 0) begin
         foreach (tbl_valid[i]) tbl_valid[i] = 1'b0;
         tracked = 0;
      end else begin
         hit = ENTRIES;
         free_slot = ENTRIES;
         for (int i = 0; i < ENTRIES; i++) begin
            if (tbl_valid[i]) begin
               if (hit == ENTRIES && tbl_key[i] == r.flow_key) hit = i;
            end else if (free_slot == ENTRIES) begin
               free_slot = i;
            end
         end
         if (hit < ENTRIES) begin
            if (age_of(r.now_ms, tbl_time[hit]) > ival) begin
               tbl_time[hit] = r.now_ms;
               if (hit != head_new) begin
                  list_remove(hit);
                  list_push(hit, 1'b0);
               end
            end else begin
               v.verdict = VERDICT_FORBID;
            end
         end else if (free_slot < ENTRIES) begin
            tbl_valid[free_slot] = 1'b1;
            tbl_key[free_slot]   = r.flow_key;
            tbl_time[free_slot]  = r.now_ms;
            list_push(free_slot, tracked == 0);
            tracked++;
         end else begin
            v.verdict = VERDICT_FULL;
         end
      end
      v.entry_count = tracked[COUNT_OUT_W-1:0];
      return v;
   endfunction

   // ---------------------------------------------------------------------------
   // Driver: offers queued requests at the falling edge; the predictor runs
   // when the rising edge shows the transaction accepted.
   // ---------------------------------------------------------------------------
   int  drv_gap = 0;
   bit  req_taken = 1'b0;    // offered transaction accepted at the last rising edge
   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall) begin
         expected_verdicts.push_back(rate_limit_decide({req_flow_key, req_now_ms}));
         req_taken = 1'b1;
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (req_valid && !req_taken) begin
         // hold the stalled payload
      end else begin
         req_taken = 1'b0;
         if (drv_gap > 0) begin
            drv_gap--;
            req_valid <= 1'b0;
         end else if (pending_reqs.size() > 0) begin
            request_type r;
            r = pending_reqs.pop_front();
            req_valid    <= 1'b1;
            req_flow_key <= r.flow_key;
            req_now_ms   <= r.now_ms;
            if (!quiet && $urandom_range(0, 5) == 0) drv_gap = $urandom_range(1, 4);
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Receiver stall: random bursts, plus one long hold-off on request.
   int  mon_gap = 0;
   always @(negedge clock) begin
      if (long_hold) begin
         rsp_stall <= 1'b1;
         hold_cycles++;
      end else if (mon_gap > 0) begin
         mon_gap--;
         rsp_stall <= 1'b1;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
         mon_gap = $urandom_range(0, 3);
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // Monitor: compare each accepted result with the oldest expectation.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_verdicts.size() == 0) begin
            $display("%0t: unexpected result verdict=%0d count=%0d",
                     $realtime, rsp_verdict, rsp_entry_count);
            failures++;
         end else begin
            verdict_type e;
            e = expected_verdicts.pop_front();
            if (rsp_verdict !== e.verdict) begin
               $display("%0t: verdict mismatch expected %0d actual %0d",
                        $realtime, e.verdict, rsp_verdict);
               failures++;
            end
            if (rsp_entry_count !== e.entry_count) begin
               $display("%0t: entry_count mismatch expected %0d actual %0d",
                        $realtime, e.entry_count, rsp_entry_count);
               failures++;
            end
         end
      end
   end

   // ---------------------------------------------------------------------------
   // Sequencing helpers
   // ---------------------------------------------------------------------------
   task automatic csr_write_interval(logic [IVAL_W-1:0] value);
      @(negedge clock);
      csr_psel <= 1'b1; csr_pwrite <= 1'b1; csr_paddr <= 3'd0;
      csr_pwdata <= {1'b0, value};
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      lim_interval = value;
      @(negedge clock);
      csr_psel <= 1'b0; csr_penable <= 1'b0; csr_pwrite <= 1'b0;
   endtask

   // Wait until every queued transaction has been answered, then a margin.
   task automatic drain();
      while (pending_reqs.size() > 0 || req_valid || expected_verdicts.size() > 0)
         @(posedge clock);
      repeat (DRAIN_CYC) @(posedge clock);
   endtask

   task automatic queue_req(logic [KEY_W-1:0] k, logic [TIME_W-1:0] t);
      pending_reqs.push_back('{flow_key: k, now_ms: t});
   endtask

   // Random phase: mostly keys from a small pool with advancing time,
   // occasionally wild keys and time jumps.
   task automatic random_phase(int count, ref logic [TIME_W-1:0] clk_ms);
      logic [KEY_W-1:0] k;
      for (int i = 0; i < count; i++) begin
         case ($urandom_range(0, 9))
            0: k = {$urandom, $urandom};
            1: k = ~64'(($urandom_range(0, key_pool_size - 1)));
            default: k = 64'($urandom_range(0, key_pool_size - 1)) | 64'hA5A5_0000_0000_0000;
         endcase
         case ($urandom_range(0, 19))
            0: clk_ms = $urandom;
            1: clk_ms -= $urandom_range(0, 3000);
            default: clk_ms += $urandom_range(0, 600);
         endcase
         queue_req(k, clk_ms);
      end
   endtask

   logic [TIME_W-1:0] t_ms;
   initial begin
      lim_interval = '0;
      foreach (tbl_valid[i]) tbl_valid[i] = 1'b0;
      head_new = 0; tail_old = 0; tracked = 0;
      repeat (8) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      // Directed: disabled block allows everything and reports zero entries.
      queue_req('0, '0);
      queue_req('1, '1);
      drain();

      csr_write_interval(31'd1000);
      // Insert, forbid within interval, allow after, wrap of time.
      queue_req(64'h1, 32'd0);
      queue_req(64'h1, 32'd500);
      queue_req(64'h1, 32'd1000);      // age == interval: expired then reinserted
      queue_req(64'h1, 32'd1500);
      queue_req(64'h1, 32'd2501);
      queue_req(64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FF00);
      queue_req(64'hFFFF_FFFF_FFFF_FFFF, 32'h0000_0100); // wraps past zero
      queue_req(64'h2, 32'h0000_0000);  // negative age for the older entries
      drain();

      // Table full: 66 distinct keys at the same time, then one more.
      for (int i = 0; i < ENTRIES + 2; i++) queue_req(64'h100 + i, 32'd10_000);
      queue_req(64'h100, 32'd10_001);   // known key still forbidden
      drain();

      // Extreme interval, then back to disabled to clear.
      csr_write_interval(31'h7FFF_FFFF);
      queue_req(64'h100, 32'h8000_0000);
      queue_req(64'h5, 32'h7FFF_FFFF);
      drain();
      csr_write_interval(31'd0);
      queue_req(64'h5, 32'd3);
      drain();

      // Random phases over several intervals.
      t_ms = $urandom;
      csr_write_interval(31'd700);
      key_pool_size = 8;
      random_phase(150, t_ms);
      drain();

      csr_write_interval(31'd1);
      key_pool_size = 96;
      random_phase(150, t_ms);
      // Long receiver hold-off while the sender keeps offering.
      random_phase(60, t_ms);
      while (expected_verdicts.size() < 2) @(posedge clock);
      long_hold = 1'b1;
      while (hold_cycles < 300) @(posedge clock);
      long_hold = 1'b0;
      drain();

      csr_write_interval(31'd2500);
      key_pool_size = 80;
      random_phase(150, t_ms);
      drain();

      csr_write_interval(31'($urandom));
      key_pool_size = 20;
      quiet = 1'b1;
      random_phase(120, t_ms);
      drain();

      if (failures == 0 && expected_verdicts.size() == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

   initial begin
      #20ms;
      $display("Test completed with failures");
      $finish;
   end

endmodule
